>>> rtl/qdiv_pkg.sv
// Shared types, constants and helper functions of the Q16.16 divider.
// No dependencies; compile before the interfaces and modules.
package qdiv_pkg;

    localparam int unsigned W = 32;

    localparam logic [W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [W-1:0] ERR_Q16 = 32'h8000_0000;

    // Width of a leading-zero count or shift amount, 0..W inclusive
    localparam int unsigned LZW = $clog2(W) + 1;

    // Shift amounts at or above this put the 1.0 marker past the top bit
    localparam logic [LZW-1:0] MAX_SHIFT = LZW'(16);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM1,
        S_NORM2,
        S_DIV,
        S_FIX,
        S_SIGN
    } t_state;

    // Status from the shared compare/subtract unit
    typedef struct packed {
        logic fits;      // divisor <= remainder
        logic rem_zero;  // remainder is zero
    } t_step_stat;

    // Magnitude of a two's complement word; the most negative value stays 0x80000000
    function automatic logic [W-1:0] mag32(input logic [W-1:0] v);
        logic [W-1:0] res;
        res = v[W-1] ? (W'(0) - v) : v;
        return res;
    endfunction

    // Leading-zero count; all zero gives W
    function automatic logic [LZW-1:0] lzc32(input logic [W-1:0] v);
        logic [LZW-1:0] cnt;
        cnt = LZW'(W);
        for (int i = 0; i < W; i++) begin
            if (v[i]) begin
                cnt = LZW'(W - 1 - i);
            end
        end
        return cnt;
    endfunction

endpackage

>>> rtl/qdiv_in_if.sv
// Operand channel of the divider: valid/ready handshake with dividend and divisor.
// Depends on qdiv_pkg for the word width.
interface qdiv_in_if;
    import qdiv_pkg::*;

    logic                valid;
    logic                ready;
    logic signed [W-1:0] dividend;
    logic signed [W-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

>>> rtl/qdiv_out_if.sv
// Result channel of the divider: valid/ready handshake with the quotient.
// Depends on qdiv_pkg for the word width.
interface qdiv_out_if;
    import qdiv_pkg::*;

    logic                valid;
    logic                ready;
    logic signed [W-1:0] quotient;

    modport source (output valid, output quotient, input ready);
    modport sink   (input valid, input quotient, output ready);
endinterface

>>> rtl/q16_restoring_divider.sv
// Top level of the signed Q16.16 restoring divider: sequencer and registers.
// Depends on qdiv_pkg, qdiv_in_if, qdiv_out_if and qdiv_step.
//
// Usage:
//   i_in  carries dividend and divisor (signed Q16.16); a transfer happens when
//         valid and ready are both high. Ready is high only while the unit is idle.
//   o_out carries the signed Q16.16 quotient; 0x80000000 flags a zero divisor or
//         a quotient that does not fit.
// Sequence: magnitudes are taken at the transfer edge, then normalization in
//   S_NORM1 (leading-zero count) and S_NORM2 (shift and compare), one cycle per
//   quotient bit in the shared subtract unit (up to 32, fewer when the
//   remainder reaches zero), a round-up state (S_FIX) and a sign state (S_SIGN).
//   A zero divisor goes from the transfer straight to the sign state.
// Throughput: one item at a time, so the bit loop sets the rate while the
//   result side keeps up.
// Reset: i_rst_n (synchronous, active low) returns the sequencer to idle and
//   drops the output valid; no operation is kept.
// Stall: the quotient sits in an output register until o_out.ready; the unit
//   already returns to idle and takes the next operands, but a second result
//   waits in the sign cycle until the output register is free.
module q16_restoring_divider (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qdiv_in_if.sink    i_in,
    qdiv_out_if.source o_out
);
    import qdiv_pkg::*;

    t_state       r_state, n_state;
    logic [W-1:0] r_rem, n_rem;
    logic [W-1:0] r_dv, n_dv;
    logic [W-1:0] r_mark, n_mark;
    logic [W-1:0] r_q, n_q;
    logic [LZW-1:0] r_k, n_k;
    logic         r_neg, n_neg;
    logic         r_err, n_err;
    logic         r_exit, n_exit;
    logic         r_out_valid, n_out_valid;
    logic [W-1:0] r_quot, n_quot;

    logic [W-1:0] step_rem;
    logic [W-1:0] step_q;
    t_step_stat   step_stat;

    logic [LZW-1:0] lz_dv;
    logic [LZW-1:0] lz_rem;
    logic [W-1:0]   dv_shift;
    logic [W-1:0]   dv_norm;
    logic           dv_low;
    logic [LZW-1:0] k_norm;
    logic [W-1:0]   mark_norm;
    logic [W-1:0]   result;
    logic           out_free;

    // Shared restoring step
    qdiv_step u_step (
        .i_rem  (r_rem),
        .i_dv   (r_dv),
        .i_mark (r_mark),
        .i_q    (r_q),
        .o_rem  (step_rem),
        .o_q    (step_q),
        .o_stat (step_stat)
    );

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.quotient = r_quot;
    assign out_free       = !r_out_valid || o_out.ready;

    // Normalization helpers
    always_comb begin
        lz_dv     = lzc32(r_dv);
        lz_rem    = lzc32(r_rem);
        dv_shift  = r_dv << r_k[LZW-2:0];
        dv_low    = (dv_shift < r_rem);
        dv_norm   = dv_low ? {dv_shift[W-2:0], 1'b0} : dv_shift;
        k_norm    = r_k + LZW'(dv_low);
        mark_norm = ONE_Q16 << k_norm[LZW-3:0];
    end

    // Apply the sign last
    always_comb begin
        if (r_err) begin
            result = ERR_Q16;
        end else if (!r_neg) begin
            result = r_q;
        end else if (r_q == ERR_Q16) begin
            result = ERR_Q16;
        end else begin
            result = W'(0) - r_q;
        end
    end

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_dv        = r_dv;
        n_mark      = r_mark;
        n_q         = r_q;
        n_k         = r_k;
        n_neg       = r_neg;
        n_err       = r_err;
        n_exit      = r_exit;
        n_out_valid = r_out_valid;
        n_quot      = r_quot;

        // Drop the output once transferred
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_rem   = mag32(i_in.dividend);
                    n_dv    = mag32(i_in.divisor);
                    n_neg   = i_in.dividend[W-1] ^ i_in.divisor[W-1];
                    n_err   = (i_in.divisor == '0);
                    n_q     = '0;
                    n_exit  = 1'b0;
                    n_state = (i_in.divisor == '0) ? S_SIGN : S_NORM1;
                end
            end
            S_NORM1: begin
                n_k     = (lz_dv > lz_rem) ? (lz_dv - lz_rem) : '0;
                n_state = S_NORM2;
            end
            S_NORM2: begin
                if (k_norm >= MAX_SHIFT) begin
                    n_err   = 1'b1;
                    n_state = S_SIGN;
                end else begin
                    // Back off one place if the divisor reached the top bit
                    if (dv_norm[W-1]) begin
                        n_dv   = dv_norm >> 1;
                        n_mark = mark_norm >> 1;
                    end else begin
                        n_dv   = dv_norm;
                        n_mark = mark_norm;
                    end
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (step_stat.rem_zero) begin
                    n_exit  = 1'b1;
                    n_state = S_FIX;
                end else begin
                    n_rem  = step_rem;
                    n_q    = step_q;
                    n_mark = r_mark >> 1;
                    if (r_mark[0]) begin
                        n_state = S_FIX;
                    end
                end
            end
            S_FIX: begin
                // Round up when the loop ran out and the divisor still fits
                if (!r_exit && step_stat.fits) begin
                    n_q = r_q + W'(1);
                end
                n_state = S_SIGN;
            end
            S_SIGN: begin
                if (out_free) begin
                    n_quot      = result;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dv   <= n_dv;
        r_mark <= n_mark;
        r_q    <= n_q;
        r_k    <= n_k;
        r_neg  <= n_neg;
        r_err  <= n_err;
        r_exit <= n_exit;
        r_quot <= n_quot;
    end

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("operand channel ready right after a transfer");

    a_mark_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> $onehot(r_mark))
        else $error("quotient marker not one-hot in the bit loop");

    a_dv_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_dv[W-1])
        else $error("divisor top bit set in the bit loop");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGN && out_free) |=> (o_out.valid && r_state == S_IDLE))
        else $error("sign cycle did not load the output register");
`endif

endmodule

>>> rtl/qdiv_step.sv
// Shared compare/subtract/shift unit: one restoring division step per use.
// Depends on qdiv_pkg.
module qdiv_step (
    input  logic [qdiv_pkg::W-1:0] i_rem,
    input  logic [qdiv_pkg::W-1:0] i_dv,
    input  logic [qdiv_pkg::W-1:0] i_mark,
    input  logic [qdiv_pkg::W-1:0] i_q,
    output logic [qdiv_pkg::W-1:0] o_rem,
    output logic [qdiv_pkg::W-1:0] o_q,
    output qdiv_pkg::t_step_stat   o_stat
);
    import qdiv_pkg::*;

    logic [W-1:0] diff;
    logic [W-1:0] kept;

    // Compare and subtract; keep the remainder when the divisor does not fit
    always_comb begin
        o_stat.fits     = (i_dv <= i_rem);
        o_stat.rem_zero = (i_rem == '0);
        diff            = i_rem - i_dv;
        kept            = o_stat.fits ? diff : i_rem;
        // Double the remainder; the top bit drops
        o_rem           = {kept[W-2:0], 1'b0};
        o_q             = o_stat.fits ? (i_q | i_mark) : i_q;
    end

endmodule
